### rtl/gasp_pkg.sv
package gasp_pkg;

  // Grid geometry
  localparam int X_BITS   = 6;
  localparam int Y_BITS   = 6;
  localparam int IDX_BITS = X_BITS + Y_BITS;
  localparam int DEPTH    = 1 << IDX_BITS;
  localparam int LEN_BITS = IDX_BITS + 1;
  localparam int DIM_BITS = 7;
  localparam int CREG_BITS = 12;
  localparam int STEP_BITS = CREG_BITS + 1;

  localparam logic [DIM_BITS-1:0] X_MAX = DIM_BITS'(1 << X_BITS);
  localparam logic [DIM_BITS-1:0] Y_MAX = DIM_BITS'(1 << Y_BITS);

  // Heuristic root extraction
  localparam int HN_BITS   = 38;
  localparam int HR_BITS   = 19;
  localparam int HREM_BITS = HR_BITS + 3;

  // Commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Result status codes
  localparam logic [2:0] STS_ACK     = 3'd0;
  localparam logic [2:0] STS_FOUND   = 3'd1;
  localparam logic [2:0] STS_NO_PATH = 3'd2;
  localparam logic [2:0] STS_OOB     = 3'd3;
  localparam logic [2:0] STS_CELL    = 3'd4;

  // Node status codes
  localparam logic [1:0] NODE_FREE   = 2'd0;
  localparam logic [1:0] NODE_OPEN   = 2'd1;
  localparam logic [1:0] NODE_CLOSED = 2'd2;

  // Map cell codes
  localparam logic [1:0] CELL_FREE    = 2'd0;
  localparam logic [1:0] CELL_BLOCK_A = 2'd1;
  localparam logic [1:0] CELL_BLOCK_B = 2'd2;
  localparam logic [1:0] CELL_COSTLY  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_COST_STRAIGHT = 2'd2;
  localparam logic [1:0] REG_COST_DIAGONAL = 2'd3;

  localparam logic [DIM_BITS-1:0]  RST_GRID_W = 7'd64;
  localparam logic [DIM_BITS-1:0]  RST_GRID_H = 7'd64;
  localparam logic [CREG_BITS-1:0] RST_COST_S = 12'd16;
  localparam logic [CREG_BITS-1:0] RST_COST_D = 12'd23;

  // Neighbor offsets, two-bit signed: W, E, N, S, NW, SW, SE, NE
  localparam logic [1:0] STEP_DX [0:7] =
    '{2'b11, 2'b01, 2'b00, 2'b00, 2'b11, 2'b11, 2'b01, 2'b01};
  localparam logic [1:0] STEP_DY [0:7] =
    '{2'b00, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b11, 2'b01};

  typedef struct packed {
    logic [1:0]          cmd;
    logic [X_BITS-1:0]   pos_x;
    logic [Y_BITS-1:0]   pos_y;
    logic [1:0]          cell_code;
    logic [DIM_BITS-1:0] goal_x;
    logic [DIM_BITS-1:0] goal_y;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [X_BITS-1:0]   out_x;
    logic [Y_BITS-1:0]   out_y;
    logic [LEN_BITS-1:0] path_length;
    logic                last_cell;
  } rsp_t;

  typedef struct packed {
    logic                 start;
    logic [X_BITS-1:0]    px;
    logic [Y_BITS-1:0]    py;
    logic [X_BITS-1:0]    gx;
    logic [Y_BITS-1:0]    gy;
    logic [CREG_BITS-1:0] cs;
  } heur_req_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD_WAIT, ST_CLR, ST_H_START, ST_H_WAIT, ST_SCAN,
    ST_SCAN_LAST, ST_SELECT, ST_EXP_ADDR, ST_EXP_EVAL, ST_EXP_HEUR, ST_TRACE,
    ST_TRACE_STEP
  } top_state_e;

  typedef enum logic [2:0] {
    HS_IDLE, HS_MUL1, HS_MUL2, HS_ROOT, HS_ROUND, HS_DONE
  } heur_state_e;

endpackage

### rtl/gasp_heur.sv
module gasp_heur import gasp_pkg::*; #(
  parameter int COST_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  heur_req_t            req_i,
  output logic                 done_o,
  output logic [COST_BITS-1:0] h_o
);

  localparam logic [32:0] COST_MAX = (33'd1 << COST_BITS) - 33'd1;

  heur_state_e hst_q, hst_d;

  logic [X_BITS-1:0]    dx;
  logic [Y_BITS-1:0]    dy;
  logic [2*X_BITS-1:0]  sqx;
  logic [2*X_BITS-1:0]  sqy;
  logic [12:0]          d2_in, d2_q;
  logic [CREG_BITS-1:0] mcs_q;
  logic [24:0]          m1_q;
  logic [HN_BITS-1:0]   rad_q;
  logic [HR_BITS-1:0]   root_q;
  logic [HREM_BITS-1:0] rem_q, rem_sh, trial;
  logic [4:0]           cnt_q;
  logic [HR_BITS:0]     rnd;
  logic [COST_BITS-1:0] h_q;

  assign dx    = (req_i.gx > req_i.px) ? req_i.gx - req_i.px : req_i.px - req_i.gx;
  assign dy    = (req_i.gy > req_i.py) ? req_i.gy - req_i.py : req_i.py - req_i.gy;
  assign sqx   = {{X_BITS{1'b0}}, dx} * {{X_BITS{1'b0}}, dx};
  assign sqy   = {{Y_BITS{1'b0}}, dy} * {{Y_BITS{1'b0}}, dy};
  assign d2_in = {1'b0, sqx} + {1'b0, sqy};

  // One root bit per cycle
  assign rem_sh = {rem_q[HREM_BITS-3:0], rad_q[HN_BITS-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign rnd    = {1'b0, root_q} + {{HR_BITS{1'b0}}, (rem_q > {3'b000, root_q})};

  always_comb begin
    hst_d = hst_q;
    case (hst_q)
      HS_IDLE:  if (req_i.start) hst_d = HS_MUL1;
      HS_MUL1:  hst_d = HS_MUL2;
      HS_MUL2:  hst_d = HS_ROOT;
      HS_ROOT:  if (cnt_q == 5'(HR_BITS - 1)) hst_d = HS_ROUND;
      HS_ROUND: hst_d = HS_DONE;
      HS_DONE:  hst_d = HS_IDLE;
      default:  hst_d = HS_IDLE;
    endcase
  end

  always_comb begin
    done_o = (hst_q == HS_DONE);
    h_o    = h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q <= HS_IDLE;
      cnt_q <= '0;
    end else begin
      hst_q <= hst_d;
      if (hst_q == HS_MUL2) cnt_q <= '0;
      else if (hst_q == HS_ROOT) cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (hst_q)
      HS_IDLE: begin
        if (req_i.start) begin
          d2_q  <= d2_in;
          mcs_q <= req_i.cs;
        end
      end
      HS_MUL1: m1_q <= 25'(d2_q) * 25'(mcs_q);
      HS_MUL2: begin
        rad_q  <= HN_BITS'(m1_q) * HN_BITS'(mcs_q);
        root_q <= '0;
        rem_q  <= '0;
      end
      HS_ROOT: begin
        rad_q <= {rad_q[HN_BITS-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[HR_BITS-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[HR_BITS-2:0], 1'b0};
        end
      end
      HS_ROUND: begin
        if (33'(rnd) > COST_MAX) h_q <= COST_MAX[COST_BITS-1:0];
        else h_q <= COST_BITS'(rnd);
      end
      default: ;
    endcase
  end

endmodule

### rtl/grid_astar_planner_top.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_req_i   (req_t)
// out      output     out_valid_o / out_ready_i  out_rsp_o  (rsp_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_addr_i, cfg_data_i
//
// Flow: load and unknown commands answer straight from idle, reads pass a wait
// state. A search clears the node store, computes the start heuristic, then per
// expansion scans the open cells through the node memory read port and
// evaluates each neighbor, waiting on the shared root unit for a new cell.
// Reset: a clearing pass writes every map cell free; no request is taken
// meanwhile, configuration writes always are.
// Stalls: one request is worked at a time; the output register holds a result
// until taken, and a request is taken in the cycle the output slot frees.
module grid_astar_planner_top import gasp_pkg::*; #(
  parameter int COST_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_addr_i,
  input  logic [CREG_BITS-1:0] cfg_data_i
);

  // Node word: status, g, h, parent direction
  localparam int PAR_LSB = 0;
  localparam int H_LSB   = 3;
  localparam int G_LSB   = H_LSB + COST_BITS;
  localparam int ST_LSB  = G_LSB + COST_BITS;
  localparam int NODE_W  = ST_LSB + 2;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);

  top_state_e state_q, state_d;

  // Configuration
  logic [DIM_BITS-1:0]  gw_q, gh_q, eff_w, eff_h;
  logic [CREG_BITS-1:0] cs_q, cd_q;

  // Memories
  logic [1:0]          cm_mem [DEPTH];
  logic [NODE_W-1:0]   nd_mem [DEPTH];
  logic [IDX_BITS-1:0] ps_mem [DEPTH];
  logic [1:0]          cm_rd_q, cm_wd;
  logic [NODE_W-1:0]   node_rd_q, nd_wd;
  logic [IDX_BITS-1:0] ps_rd_q, ps_wd, ps_wa, ps_ra, cm_wa, nd_wa, nd_ra;
  logic                cm_we, nd_we, ps_we;

  // Control and datapath registers
  logic [IDX_BITS-1:0]  clr_q, clr_d;
  logic [X_BITS-1:0]    sx_q, sx_d, gx_q, gx_d, scx_q, scx_d;
  logic [Y_BITS-1:0]    sy_q, sy_d, gy_q, gy_d, scy_q, scy_d;
  logic                 sc_vld_q, sc_vld_d, any_q, any_d;
  logic [IDX_BITS-1:0]  sc_addr_q, sc_addr_d, best_idx_q, best_idx_d;
  logic [COST_BITS:0]   best_f_q, best_f_d, sc_f, gsum;
  logic [COST_BITS-1:0] best_g_q, best_g_d, best_h_q, best_h_d, gnew_q, gnew_d, gnew;
  logic [2:0]           best_par_q, best_par_d, k_q, k_d;
  logic [IDX_BITS-1:0]  ni_q, ni_d, idx_q, idx_d, ni, tr_next, start_idx;
  logic [LEN_BITS-1:0]  n_q, n_d, rp_q, rp_d, len_q, len_d;
  rsp_t                 out_q, out_d, res;
  logic                 out_vld_q, out_vld_d, res_emit;

  // Decode
  logic                 in_acc, srch_oob, nb_ok, scan_last, sc_take, last_k;
  logic                 ev_blocked, ev_closed, ev_open, ev_better, best_is_goal, trace_end;
  logic [1:0]           rd_st, dxk, dyk, tdx, tdy;
  logic [COST_BITS-1:0] rd_g, rd_h;
  logic [2:0]           rd_par;
  logic [7:0]           nx8, ny8;
  logic [X_BITS-1:0]    cur_x;
  logic [Y_BITS-1:0]    cur_y;
  logic [CREG_BITS-1:0] stp12;
  logic [STEP_BITS-1:0] step;

  heur_req_t            h_req;
  logic                 h_done;
  logic [COST_BITS-1:0] h_res;

  gasp_heur #(.COST_BITS(COST_BITS)) u_heur (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (h_req),
    .done_o (h_done),
    .h_o    (h_res)
  );

  // Clamp grid size to the addressable array
  assign eff_w = (gw_q > X_MAX) ? X_MAX : gw_q;
  assign eff_h = (gh_q > Y_MAX) ? Y_MAX : gh_q;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  assign srch_oob = ({1'b0, in_req_i.pos_x} >= eff_w) || ({1'b0, in_req_i.pos_y} >= eff_h) ||
                    (in_req_i.goal_x >= eff_w) || (in_req_i.goal_y >= eff_h);

  assign rd_st  = node_rd_q[ST_LSB +: 2];
  assign rd_g   = node_rd_q[G_LSB +: COST_BITS];
  assign rd_h   = node_rd_q[H_LSB +: COST_BITS];
  assign rd_par = node_rd_q[PAR_LSB +: 3];

  // Neighbor of the selected cell
  assign cur_x = best_idx_q[X_BITS-1:0];
  assign cur_y = best_idx_q[IDX_BITS-1:X_BITS];
  assign dxk   = STEP_DX[k_q];
  assign dyk   = STEP_DY[k_q];
  assign nx8   = {2'b00, cur_x} + {{6{dxk[1]}}, dxk};
  assign ny8   = {2'b00, cur_y} + {{6{dyk[1]}}, dyk};
  assign nb_ok = !nx8[7] && !ny8[7] && (nx8[6:0] < eff_w) && (ny8[6:0] < eff_h);
  assign ni    = {ny8[Y_BITS-1:0], nx8[X_BITS-1:0]};
  assign last_k = (k_q == 3'd7);

  // Step cost and saturating g
  assign stp12 = k_q[2] ? cd_q : cs_q;
  assign step  = (cm_rd_q == CELL_COSTLY) ? {stp12, 1'b0} : {1'b0, stp12};
  assign gsum  = {1'b0, best_g_q} + (COST_BITS+1)'(step);
  assign gnew  = gsum[COST_BITS] ? {COST_BITS{1'b1}} : gsum[COST_BITS-1:0];

  assign ev_blocked = (cm_rd_q == CELL_BLOCK_A) || (cm_rd_q == CELL_BLOCK_B);
  assign ev_closed  = (rd_st == NODE_CLOSED);
  assign ev_open    = (rd_st == NODE_OPEN);
  assign ev_better  = (rd_g > gnew);

  // Scan compare: strict less keeps the lower index on ties
  assign scan_last = ({1'b0, scx_q} == eff_w - 7'd1) && ({1'b0, scy_q} == eff_h - 7'd1);
  assign sc_f      = {1'b0, rd_g} + {1'b0, rd_h};
  assign sc_take   = sc_vld_q && (rd_st == NODE_OPEN) && (!any_q || (sc_f < best_f_q));

  assign start_idx    = {sy_q, sx_q};
  assign best_is_goal = (best_idx_q == {gy_q, gx_q});
  assign trace_end    = (idx_q == start_idx) || (n_q == LEN_BITS'(DEPTH));

  // Step back along the parent direction, wrapping in the array
  assign tdx     = STEP_DX[rd_par];
  assign tdy     = STEP_DY[rd_par];
  assign tr_next = {idx_q[IDX_BITS-1:X_BITS] - {{(Y_BITS-2){tdy[1]}}, tdy},
                    idx_q[X_BITS-1:0] - {{(X_BITS-2){tdx[1]}}, tdx}};

  // Path is stored goal first; read it back from the far end
  assign ps_ra = IDX_BITS'(len_q - LEN_BITS'(1) - rp_q);

  assign h_req.start = (state_q == ST_H_START) ||
                       ((state_q == ST_EXP_EVAL) && !ev_blocked && !ev_closed && !ev_open);
  assign h_req.px    = (state_q == ST_H_START) ? sx_q : ni_q[X_BITS-1:0];
  assign h_req.py    = (state_q == ST_H_START) ? sy_q : ni_q[IDX_BITS-1:X_BITS];
  assign h_req.gx    = gx_q;
  assign h_req.gy    = gy_q;
  assign h_req.cs    = cs_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:    if (clr_q == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.cmd)
            CMD_SEARCH: if (!srch_oob) state_d = ST_CLR;
            CMD_READ:   state_d = ST_RD_WAIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT:   state_d = ST_IDLE;
      ST_CLR:       if (clr_q == LAST_IDX) state_d = ST_H_START;
      ST_H_START:   state_d = ST_H_WAIT;
      ST_H_WAIT:    if (h_done) state_d = ST_SCAN;
      ST_SCAN:      if (scan_last) state_d = ST_SCAN_LAST;
      ST_SCAN_LAST: state_d = ST_SELECT;
      ST_SELECT: begin
        if (!any_q) state_d = ST_IDLE;
        else if (best_is_goal) state_d = ST_TRACE;
        else state_d = ST_EXP_ADDR;
      end
      ST_EXP_ADDR: begin
        if (nb_ok) state_d = ST_EXP_EVAL;
        else if (last_k) state_d = ST_SCAN;
      end
      ST_EXP_EVAL: begin
        if (ev_blocked || ev_closed || ev_open) state_d = last_k ? ST_SCAN : ST_EXP_ADDR;
        else state_d = ST_EXP_HEUR;
      end
      ST_EXP_HEUR:   if (h_done) state_d = last_k ? ST_SCAN : ST_EXP_ADDR;
      ST_TRACE:      state_d = trace_end ? ST_IDLE : ST_TRACE_STEP;
      ST_TRACE_STEP: state_d = ST_TRACE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d      = clr_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    gx_d       = gx_q;
    gy_d       = gy_q;
    scx_d      = scx_q;
    scy_d      = scy_q;
    sc_vld_d   = 1'b0;
    sc_addr_d  = sc_addr_q;
    any_d      = any_q;
    best_f_d   = best_f_q;
    best_idx_d = best_idx_q;
    best_g_d   = best_g_q;
    best_h_d   = best_h_q;
    best_par_d = best_par_q;
    k_d        = k_q;
    ni_d       = ni_q;
    gnew_d     = gnew_q;
    idx_d      = idx_q;
    n_d        = n_q;
    rp_d       = rp_q;
    len_d      = len_q;
    res        = '0;
    res_emit   = 1'b0;
    cm_we      = 1'b0;
    cm_wa      = clr_q;
    cm_wd      = CELL_FREE;
    nd_we      = 1'b0;
    nd_wa      = clr_q;
    nd_wd      = '0;
    nd_ra      = idx_q;
    ps_we      = 1'b0;
    ps_wa      = n_q[IDX_BITS-1:0];
    ps_wd      = tr_next;

    // Fold the word read last cycle into the running minimum
    if (sc_take) begin
      any_d      = 1'b1;
      best_f_d   = sc_f;
      best_idx_d = sc_addr_q;
      best_g_d   = rd_g;
      best_h_d   = rd_h;
      best_par_d = rd_par;
    end

    case (state_q)
      ST_INIT: begin
        cm_we = 1'b1;
        clr_d = clr_q + IDX_BITS'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.cmd)
            CMD_LOAD: begin
              cm_we    = 1'b1;
              cm_wa    = {in_req_i.pos_y, in_req_i.pos_x};
              cm_wd    = in_req_i.cell_code;
              res_emit = 1'b1;
            end
            CMD_SEARCH: begin
              len_d = '0;
              rp_d  = '0;
              clr_d = '0;
              sx_d  = in_req_i.pos_x;
              sy_d  = in_req_i.pos_y;
              gx_d  = in_req_i.goal_x[X_BITS-1:0];
              gy_d  = in_req_i.goal_y[Y_BITS-1:0];
              if (srch_oob) begin
                res.status = STS_OOB;
                res_emit   = 1'b1;
              end
            end
            CMD_READ: ;
            default: res_emit = 1'b1;
          endcase
        end
      end
      ST_RD_WAIT: begin
        res.path_length = len_q;
        res_emit        = 1'b1;
        if (rp_q < len_q) begin
          res.status    = STS_CELL;
          res.out_x     = ps_rd_q[X_BITS-1:0];
          res.out_y     = ps_rd_q[IDX_BITS-1:X_BITS];
          res.last_cell = (rp_q + LEN_BITS'(1) == len_q);
          rp_d          = rp_q + LEN_BITS'(1);
        end else begin
          res.status = STS_NO_PATH;
        end
      end
      ST_CLR: begin
        nd_we = 1'b1;
        nd_wd = {NODE_FREE, {(NODE_W-2){1'b0}}};
        clr_d = clr_q + IDX_BITS'(1);
      end
      ST_H_WAIT: begin
        if (h_done) begin
          nd_we = 1'b1;
          nd_wa = start_idx;
          nd_wd = {NODE_OPEN, {COST_BITS{1'b0}}, h_res, 3'd0};
        end
      end
      ST_SCAN: begin
        nd_ra     = {scy_q, scx_q};
        sc_vld_d  = 1'b1;
        sc_addr_d = {scy_q, scx_q};
        if ({1'b0, scx_q} == eff_w - 7'd1) begin
          scx_d = '0;
          scy_d = scy_q + Y_BITS'(1);
        end else begin
          scx_d = scx_q + X_BITS'(1);
        end
      end
      ST_SELECT: begin
        if (!any_q) begin
          res.status = STS_NO_PATH;
          res_emit   = 1'b1;
        end else if (best_is_goal) begin
          ps_we = 1'b1;
          ps_wa = '0;
          ps_wd = best_idx_q;
          idx_d = best_idx_q;
          n_d   = LEN_BITS'(1);
        end else begin
          nd_we = 1'b1;
          nd_wa = best_idx_q;
          nd_wd = {NODE_CLOSED, best_g_q, best_h_q, best_par_q};
          k_d   = '0;
        end
      end
      ST_EXP_ADDR: begin
        nd_ra = ni;
        ni_d  = ni;
        if (!nb_ok) k_d = k_q + 3'd1;
      end
      ST_EXP_EVAL: begin
        gnew_d = gnew;
        if (ev_blocked || ev_closed) begin
          k_d = k_q + 3'd1;
        end else if (ev_open) begin
          if (ev_better) begin
            nd_we = 1'b1;
            nd_wa = ni_q;
            nd_wd = {NODE_OPEN, gnew, rd_h, k_q};
          end
          k_d = k_q + 3'd1;
        end
      end
      ST_EXP_HEUR: begin
        if (h_done) begin
          nd_we = 1'b1;
          nd_wa = ni_q;
          nd_wd = {NODE_OPEN, gnew_q, h_res, k_q};
          k_d   = k_q + 3'd1;
        end
      end
      ST_TRACE: begin
        nd_ra = idx_q;
        if (trace_end) begin
          res.status      = STS_FOUND;
          res.path_length = n_q;
          res_emit        = 1'b1;
          len_d           = n_q;
          rp_d            = '0;
        end
      end
      ST_TRACE_STEP: begin
        ps_we = 1'b1;
        idx_d = tr_next;
        n_d   = n_q + LEN_BITS'(1);
      end
      default: ;
    endcase

    // Restart the scan from the first cell
    if ((state_d == ST_SCAN) && (state_q != ST_SCAN)) begin
      scx_d = '0;
      scy_d = '0;
      any_d = 1'b0;
    end

    out_d     = res_emit ? res : out_q;
    out_vld_d = res_emit || (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      gw_q      <= RST_GRID_W;
      gh_q      <= RST_GRID_H;
      cs_q      <= RST_COST_S;
      cd_q      <= RST_COST_D;
      clr_q     <= '0;
      scx_q     <= '0;
      scy_q     <= '0;
      sc_vld_q  <= 1'b0;
      any_q     <= 1'b0;
      k_q       <= '0;
      n_q       <= '0;
      rp_q      <= '0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      scx_q     <= scx_d;
      scy_q     <= scy_d;
      sc_vld_q  <= sc_vld_d;
      any_q     <= any_d;
      k_q       <= k_d;
      n_q       <= n_d;
      rp_q      <= rp_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_GRID_WIDTH:    gw_q <= cfg_data_i[DIM_BITS-1:0];
          REG_GRID_HEIGHT:   gh_q <= cfg_data_i[DIM_BITS-1:0];
          REG_COST_STRAIGHT: cs_q <= cfg_data_i;
          REG_COST_DIAGONAL: cd_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    gx_q       <= gx_d;
    gy_q       <= gy_d;
    sc_addr_q  <= sc_addr_d;
    best_f_q   <= best_f_d;
    best_idx_q <= best_idx_d;
    best_g_q   <= best_g_d;
    best_h_q   <= best_h_d;
    best_par_q <= best_par_d;
    ni_q       <= ni_d;
    gnew_q     <= gnew_d;
    idx_q      <= idx_d;
    out_q      <= out_d;
  end

  // Map, node and path memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cm_we) cm_mem[cm_wa] <= cm_wd;
    cm_rd_q <= cm_mem[ni];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) nd_mem[nd_wa] <= nd_wd;
    node_rd_q <= nd_mem[nd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    ps_rd_q <= ps_mem[ps_ra];
  end

  // A result lands only in a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_emit |-> (!out_vld_q || out_ready_i))
    else $error("result overwrites a pending output");

  // The scan must not see node writes under it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !nd_we)
    else $error("node write during open-cell scan");

  // The heuristic unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_done |-> ((state_q == ST_H_WAIT) || (state_q == ST_EXP_HEUR)))
    else $error("heuristic result with no waiting request");

  // Path trace stays within the path store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRACE_STEP) |-> (n_q < LEN_BITS'(DEPTH)))
    else $error("path trace overruns path store");

endmodule
